>>> hdl/assert_macros.svh
// Clocked assertion helpers, sampled at the rising edge of aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`define ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hdl/utcc_pkg.sv
package utcc_pkg;

    localparam int CODEPOINT_SPACE = 1114112;
    localparam int CP_W            = 21;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W:0]   SPACE_L = (CP_W+1)'(CODEPOINT_SPACE);

    localparam int ROW_BITS = 64;
    localparam int BIT_W    = $clog2(ROW_BITS);
    localparam int MAP_ROWS = (CODEPOINT_SPACE + ROW_BITS - 1) / ROW_BITS;
    localparam int ROW_W    = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_NEW = 2'd0,
        ST_DUP = 2'd1,
        ST_BAD = 2'd2
    } status_t;

    typedef enum logic {
        JOB_LOOKUP = 1'b0,
        JOB_BAD    = 1'b1
    } job_kind_t;

    typedef struct packed {
        job_kind_t       kind;
        logic [CP_W-1:0] cp;
        logic [31:0]     bytes;
        logic [2:0]      count;
    } job_t;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
    } enc_t;

    function automatic logic in_space(input logic [CP_W-1:0] cp);
        return (cp <= CP_MAX) && ({1'b0, cp} < SPACE_L);
    endfunction

    function automatic enc_t encode(input logic [CP_W-1:0] cp);
        enc_t e;
        if (cp <= 21'h7F) begin
            e.bytes = {24'b0, 1'b0, cp[6:0]};
            e.count = 3'd1;
        end else if (cp <= 21'h7FF) begin
            e.bytes = {16'b0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            e.count = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            e.bytes = {8'b0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            e.count = 3'd3;
        end else begin
            e.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
            e.count = 3'd4;
        end
        return e;
    endfunction

endpackage

>>> hdl/utf8_unique_codepoint_collector.sv
// Path: a completed codepoint passes the job queue, the lookup stage and the output register.
// Throughput: one word per cycle while s_ready is high; a seen-map row read per result,
// a write per new codepoint, forwarded when consecutive codepoints share a 64-bit row.
// Reset: synchronous, active low; a clearing pass then zeroes the seen map one row a
// cycle across all 17408 rows, with s_ready held low until it ends.
module utf8_unique_codepoint_collector (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [7:0]                    s_data_byte,
    input  logic [utcc_pkg::CP_W-1:0]     s_codepoint_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [utcc_pkg::CP_W-1:0]     m_codepoint_out,
    output logic [31:0]                   m_utf8_bytes,
    output logic [2:0]                    m_byte_count,
    output logic [utcc_pkg::CP_W-1:0]     m_unique_total
);

    logic           push, pop, queue_full, head_valid, init_done;
    utcc_pkg::job_t push_job, head_job;

    utcc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_data_byte    (s_data_byte),
        .s_codepoint_in (s_codepoint_in),
        .queue_full     (queue_full),
        .init_done      (init_done),
        .push           (push),
        .push_job       (push_job)
    );

    utcc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .full       (queue_full)
    );

    utcc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_job        (head_job),
        .pop             (pop),
        .init_done       (init_done),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_codepoint_out (m_codepoint_out),
        .m_utf8_bytes    (m_utf8_bytes),
        .m_byte_count    (m_byte_count),
        .m_unique_total  (m_unique_total)
    );

endmodule

>>> hdl/utcc_front.sv
module utcc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_command,
    input  logic [7:0]                      s_data_byte,
    input  logic [utcc_pkg::CP_W-1:0]       s_codepoint_in,
    input  logic                            queue_full,
    input  logic                            init_done,
    output logic                            push,
    output utcc_pkg::job_t                  push_job
);

    logic [utcc_pkg::CP_W-1:0] value_reg, value_next;
    logic [31:0]               bytes_reg, bytes_next;
    logic [2:0]                need_reg, need_next;
    logic [2:0]                seen_reg, seen_next;
    logic                      emit;
    logic                      accept;
    logic [utcc_pkg::CP_W-1:0] cont_value;
    logic [31:0]               cont_bytes;
    logic [2:0]                cont_seen;
    utcc_pkg::enc_t            enc;

    assign s_ready = !queue_full && init_done;
    assign accept  = s_valid && s_ready;
    assign push    = accept && emit;

    assign cont_value = {value_reg[utcc_pkg::CP_W-7:0], s_data_byte[5:0]};
    assign cont_bytes = bytes_reg | ({24'b0, s_data_byte} << {seen_reg[1:0], 3'b000});
    assign cont_seen  = seen_reg + 3'd1;
    assign enc        = utcc_pkg::encode(s_codepoint_in);

    always_comb begin
        value_next = value_reg;
        bytes_next = bytes_reg;
        need_next  = need_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        push_job   = '0;
        if (s_command) begin
            value_next = '0;
            bytes_next = '0;
            need_next  = '0;
            seen_next  = '0;
            emit       = 1'b1;
            if (utcc_pkg::in_space(s_codepoint_in)) begin
                push_job.kind  = utcc_pkg::JOB_LOOKUP;
                push_job.cp    = s_codepoint_in;
                push_job.bytes = enc.bytes;
                push_job.count = enc.count;
            end else begin
                push_job.kind = utcc_pkg::JOB_BAD;
            end
        end else if (need_reg == 3'd0) begin
            priority if (s_data_byte == 8'h00) begin
                emit = 1'b0;
            end else if (!s_data_byte[7]) begin
                emit           = 1'b1;
                push_job.kind  = utcc_pkg::JOB_LOOKUP;
                push_job.cp    = {13'b0, s_data_byte};
                push_job.bytes = {24'b0, s_data_byte};
                push_job.count = 3'd1;
            end else if (s_data_byte[7:5] == 3'b110) begin
                need_next  = 3'd2;
                value_next = {16'b0, s_data_byte[4:0]};
                bytes_next = {24'b0, s_data_byte};
                seen_next  = 3'd1;
            end else if (s_data_byte[7:4] == 4'b1110) begin
                need_next  = 3'd3;
                value_next = {17'b0, s_data_byte[3:0]};
                bytes_next = {24'b0, s_data_byte};
                seen_next  = 3'd1;
            end else if (s_data_byte[7:3] == 5'b11110) begin
                need_next  = 3'd4;
                value_next = {18'b0, s_data_byte[2:0]};
                bytes_next = {24'b0, s_data_byte};
                seen_next  = 3'd1;
            end else begin
                emit          = 1'b1;
                push_job.kind = utcc_pkg::JOB_BAD;
            end
        end else if (cont_seen < need_reg) begin
            value_next = cont_value;
            bytes_next = cont_bytes;
            seen_next  = cont_seen;
        end else begin
            value_next     = '0;
            bytes_next     = '0;
            need_next      = '0;
            seen_next      = '0;
            emit           = 1'b1;
            push_job.cp    = cont_value;
            push_job.bytes = cont_bytes;
            push_job.count = need_reg;
            push_job.kind  = utcc_pkg::in_space(cont_value) ? utcc_pkg::JOB_LOOKUP
                                                           : utcc_pkg::JOB_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            bytes_reg <= '0;
            need_reg  <= '0;
            seen_reg  <= '0;
        end else if (accept) begin
            value_reg <= value_next;
            bytes_reg <= bytes_next;
            need_reg  <= need_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

>>> hdl/utcc_fifo.sv
`include "assert_macros.svh"

module utcc_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  utcc_pkg::job_t push_job,
    input  logic           pop,
    output logic           head_valid,
    output utcc_pkg::job_t head_job,
    output logic           full
);

    utcc_pkg::job_t                slot_reg [utcc_pkg::QDEPTH];
    logic [utcc_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [utcc_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == utcc_pkg::QCNT_W'(utcc_pkg::QDEPTH));
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == utcc_pkg::QPTR_W'(utcc_pkg::QDEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == utcc_pkg::QPTR_W'(utcc_pkg::QDEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_no_overflow, !(push && full), "word pushed into a full queue")
    `ASSERT_CLK(a_no_underflow, !(pop && !head_valid), "pop from an empty queue")

endmodule

>>> hdl/utcc_back.sv
`include "assert_macros.svh"

module utcc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  utcc_pkg::job_t                head_job,
    output logic                          pop,
    output logic                          init_done,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [utcc_pkg::CP_W-1:0]     m_codepoint_out,
    output logic [31:0]                   m_utf8_bytes,
    output logic [2:0]                    m_byte_count,
    output logic [utcc_pkg::CP_W-1:0]     m_unique_total
);

    logic [utcc_pkg::ROW_BITS-1:0] map_mem [utcc_pkg::MAP_ROWS];

    logic                          clear_busy_reg;
    logic [utcc_pkg::ROW_W-1:0]    clear_row_reg;

    logic                          b_valid_reg;
    utcc_pkg::job_t                b_job_reg;
    logic [utcc_pkg::ROW_BITS-1:0] rdata_reg;
    logic                          fwd_hit_reg;
    logic [utcc_pkg::ROW_BITS-1:0] fwd_data_reg;

    logic [utcc_pkg::CP_W-1:0]     unique_reg, unique_next;

    logic                          m_valid_reg;
    utcc_pkg::status_t             m_status_reg;
    logic [utcc_pkg::CP_W-1:0]     m_cp_reg;
    logic [31:0]                   m_bytes_reg;
    logic [2:0]                    m_count_reg;
    logic [utcc_pkg::CP_W-1:0]     m_total_reg;

    logic [utcc_pkg::ROW_W-1:0]    b_row, head_row, wr_row;
    logic [utcc_pkg::BIT_W-1:0]    b_bit;
    logic [utcc_pkg::ROW_BITS-1:0] row_now, wr_data;
    logic                          hit, b_new, advance, map_we;

    assign b_row    = b_job_reg.cp[utcc_pkg::BIT_W +: utcc_pkg::ROW_W];
    assign b_bit    = b_job_reg.cp[utcc_pkg::BIT_W-1:0];
    assign head_row = head_job.cp[utcc_pkg::BIT_W +: utcc_pkg::ROW_W];

    assign row_now = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign hit     = row_now[b_bit];
    assign b_new   = (b_job_reg.kind == utcc_pkg::JOB_LOOKUP) && !hit;

    assign advance   = b_valid_reg && (!m_valid_reg || m_ready);
    assign pop       = head_valid && !clear_busy_reg && (!b_valid_reg || advance);
    assign init_done = !clear_busy_reg;

    assign map_we  = clear_busy_reg || (advance && b_new);
    assign wr_row  = clear_busy_reg ? clear_row_reg : b_row;
    assign wr_data = clear_busy_reg ? '0
                   : (row_now | ({{(utcc_pkg::ROW_BITS-1){1'b0}}, 1'b1} << b_bit));

    assign unique_next = unique_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[wr_row] <= wr_data;
        end
        if (pop) begin
            rdata_reg    <= map_mem[head_row];
            fwd_hit_reg  <= advance && b_new && (b_row == head_row);
            fwd_data_reg <= wr_data;
            b_job_reg    <= head_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_busy_reg <= 1'b1;
            clear_row_reg  <= '0;
            b_valid_reg    <= 1'b0;
            unique_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clear_busy_reg) begin
                clear_row_reg <= clear_row_reg + 1'b1;
                if (clear_row_reg == utcc_pkg::ROW_W'(utcc_pkg::MAP_ROWS - 1)) begin
                    clear_busy_reg <= 1'b0;
                end
            end
            if (pop) begin
                b_valid_reg <= 1'b1;
            end else if (advance) begin
                b_valid_reg <= 1'b0;
            end
            if (advance && b_new) begin
                unique_reg <= unique_next;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_cp_reg    <= '0;
            m_bytes_reg <= '0;
            m_count_reg <= '0;
            m_total_reg <= unique_reg;
            if (b_job_reg.kind == utcc_pkg::JOB_BAD) begin
                m_status_reg <= utcc_pkg::ST_BAD;
            end else if (hit) begin
                m_status_reg <= utcc_pkg::ST_DUP;
                m_cp_reg     <= b_job_reg.cp;
            end else begin
                m_status_reg <= utcc_pkg::ST_NEW;
                m_cp_reg     <= b_job_reg.cp;
                m_bytes_reg  <= b_job_reg.bytes;
                m_count_reg  <= b_job_reg.count;
                m_total_reg  <= unique_next;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_codepoint_out = m_cp_reg;
    assign m_utf8_bytes    = m_bytes_reg;
    assign m_byte_count    = m_count_reg;
    assign m_unique_total  = m_total_reg;

    `ASSERT_CLK(a_no_pop_clearing, !(clear_busy_reg && pop), "queue popped during map clear")
    `ASSERT_NEXT(a_count_on_new, advance && b_new,
                 unique_reg == $past(unique_reg) + 1'b1, "count not raised on new codepoint")
    `ASSERT_NEXT(a_count_hold, !(advance && b_new),
                 unique_reg == $past(unique_reg), "count moved without a new codepoint")

endmodule

>>> tb/utf8_unique_codepoint_collector_tb.sv
module utf8_unique_codepoint_collector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utcc_pkg::*;

    localparam int N_DIRECTED  = 25;
    localparam int N_RANDOM    = 550;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic            cmd;
        logic [7:0]      data;
        logic [CP_W-1:0] cp;
        logic            typed;
        logic [1:0]      st;
        logic [CP_W-1:0] cpo;
        logic [31:0]     bytes;
        logic [2:0]      cnt;
        logic [CP_W-1:0] total;
    } dir_row_t;

    typedef struct {
        status_t         st;
        logic [CP_W-1:0] cp;
        logic [31:0]     bytes;
        logic [2:0]      cnt;
        logic [CP_W-1:0] total;
    } cp_result_t;

    typedef struct {
        logic            cmd;
        logic [7:0]      data;
        logic [CP_W-1:0] cp;
        bit              typed;
        cp_result_t      want;
    } stim_word_t;

    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{1'b1, 8'h00, 21'h000000, 1'b1, ST_NEW, 21'h000000, 32'h00000000, 3'd1, 21'd1},
        '{1'b1, 8'h00, 21'h000000, 1'b1, ST_DUP, 21'h000000, 32'h00000000, 3'd0, 21'd1},
        '{1'b0, 8'h00, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h7F, 21'h000000, 1'b1, ST_NEW, 21'h00007F, 32'h0000007F, 3'd1, 21'd2},
        '{1'b1, 8'h00, 21'h10FFFF, 1'b1, ST_NEW, 21'h10FFFF, 32'hBFBF8FF4, 3'd4, 21'd3},
        '{1'b1, 8'h00, 21'h110000, 1'b1, ST_BAD, 21'h000000, 32'h00000000, 3'd0, 21'd3},
        '{1'b1, 8'h00, 21'h1FFFFF, 1'b1, ST_BAD, 21'h000000, 32'h00000000, 3'd0, 21'd3},
        '{1'b0, 8'h80, 21'h000000, 1'b1, ST_BAD, 21'h000000, 32'h00000000, 3'd0, 21'd3},
        '{1'b0, 8'hFF, 21'h000000, 1'b1, ST_BAD, 21'h000000, 32'h00000000, 3'd0, 21'd3},
        '{1'b0, 8'hF8, 21'h000000, 1'b1, ST_BAD, 21'h000000, 32'h00000000, 3'd0, 21'd3},
        '{1'b0, 8'hC2, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h00, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'hE2, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b1, 8'h00, 21'h0020AC, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'hE2, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h82, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'hAC, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'hF0, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h9F, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h98, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h80, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'hF4, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h90, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h80, 21'h000000, 1'b0, ST_NEW, 21'h000000, 32'h00000000, 3'd0, 21'd0},
        '{1'b0, 8'h80, 21'h000000, 1'b1, ST_BAD, 21'h000000, 32'h00000000, 3'd0, 21'd6}
    };

    localparam logic [CP_W-1:0] BOUNDARY_CPS [8] = '{
        21'h000001, 21'h00007F, 21'h000080, 21'h0007FF,
        21'h000800, 21'h00FFFF, 21'h010000, 21'h10FFFF
    };

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    logic            s_command;
    logic [7:0]      s_data_byte;
    logic [CP_W-1:0] s_codepoint_in;
    logic            m_valid;
    logic            m_ready;
    logic [1:0]      m_status;
    logic [CP_W-1:0] m_codepoint_out;
    logic [31:0]     m_utf8_bytes;
    logic [2:0]      m_byte_count;
    logic [CP_W-1:0] m_unique_total;

    bit              seen_map_q [CODEPOINT_SPACE];
    logic [CP_W-1:0] total_q      = '0;
    logic [CP_W-1:0] part_val_q   = '0;
    logic [31:0]     part_bytes_q = '0;
    logic [2:0]      part_len_q   = '0;
    logic [2:0]      part_seen_q  = '0;

    logic [CP_W-1:0] cp_pool [16];
    stim_word_t      stim_q [$];
    cp_result_t      pending_results [$];
    int              mismatch_count = 0;
    bit              hold_off_req = 1'b0;

    utf8_unique_codepoint_collector dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_data_byte     (s_data_byte),
        .s_codepoint_in  (s_codepoint_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_codepoint_out (m_codepoint_out),
        .m_utf8_bytes    (m_utf8_bytes),
        .m_byte_count    (m_byte_count),
        .m_unique_total  (m_unique_total)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [31:0] utf8_pack(input logic [CP_W-1:0] cp, output logic [2:0] n);
        logic [7:0] b0, b1, b2, b3;
        b1 = 8'h00;
        b2 = 8'h00;
        b3 = 8'h00;
        if (cp <= 21'h7F) begin
            n  = 3'd1;
            b0 = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            n  = 3'd2;
            b0 = 8'hC0 | {3'b000, cp[10:6]};
            b1 = 8'h80 | {2'b00, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            n  = 3'd3;
            b0 = 8'hE0 | {4'b0000, cp[15:12]};
            b1 = 8'h80 | {2'b00, cp[11:6]};
            b2 = 8'h80 | {2'b00, cp[5:0]};
        end else begin
            n  = 3'd4;
            b0 = 8'hF0 | {5'b00000, cp[20:18]};
            b1 = 8'h80 | {2'b00, cp[17:12]};
            b2 = 8'h80 | {2'b00, cp[11:6]};
            b3 = 8'h80 | {2'b00, cp[5:0]};
        end
        return {b3, b2, b1, b0};
    endfunction

    function automatic bit cp_in_range(input logic [CP_W-1:0] cp);
        return (cp <= CP_MAX) && (int'(cp) < CODEPOINT_SPACE);
    endfunction

    function automatic cp_result_t record_cp(input logic [CP_W-1:0] cp,
                                             input logic [31:0] raw, input logic [2:0] n);
        cp_result_t r;
        r.st    = ST_BAD;
        r.cp    = '0;
        r.bytes = '0;
        r.cnt   = '0;
        if (cp_in_range(cp)) begin
            r.cp = cp;
            if (seen_map_q[cp]) begin
                r.st = ST_DUP;
            end else begin
                seen_map_q[cp] = 1'b1;
                total_q        = total_q + 1'b1;
                r.st           = ST_NEW;
                r.bytes        = raw;
                r.cnt          = n;
            end
        end
        r.total = total_q;
        return r;
    endfunction

    function automatic void clear_partial();
        part_val_q   = '0;
        part_bytes_q = '0;
        part_len_q   = '0;
        part_seen_q  = '0;
    endfunction

    function automatic bit decode_and_collect(input stim_word_t w, output cp_result_t r);
        logic [31:0]     raw;
        logic [2:0]      n;
        logic [CP_W-1:0] cp;
        if (w.cmd) begin
            clear_partial();
            raw = utf8_pack(w.cp, n);
            r   = record_cp(w.cp, raw, n);
            return 1'b1;
        end
        if (part_len_q == 3'd0) begin
            if (w.data == 8'h00) begin
                return 1'b0;
            end
            if (!w.data[7]) begin
                r = record_cp({13'b0, w.data}, {24'b0, w.data}, 3'd1);
                return 1'b1;
            end
            if (w.data[7:5] == 3'b110) begin
                part_len_q = 3'd2;
                part_val_q = {16'b0, w.data[4:0]};
            end else if (w.data[7:4] == 4'b1110) begin
                part_len_q = 3'd3;
                part_val_q = {17'b0, w.data[3:0]};
            end else if (w.data[7:3] == 5'b11110) begin
                part_len_q = 3'd4;
                part_val_q = {18'b0, w.data[2:0]};
            end else begin
                r = record_cp(CP_W'(21'h1FFFFF), 32'h0, 3'd0);
                return 1'b1;
            end
            part_bytes_q = {24'b0, w.data};
            part_seen_q  = 3'd1;
            return 1'b0;
        end
        part_val_q   = {part_val_q[14:0], w.data[5:0]};
        part_bytes_q = part_bytes_q | ({24'b0, w.data} << (8 * part_seen_q[1:0]));
        part_seen_q  = part_seen_q + 3'd1;
        if (part_seen_q < part_len_q) begin
            return 1'b0;
        end
        cp  = part_val_q;
        raw = part_bytes_q;
        n   = part_len_q;
        clear_partial();
        r = record_cp(cp, raw, n);
        return 1'b1;
    endfunction

    function automatic logic [CP_W-1:0] rand_cp();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 9))
            0, 1:    cp = CP_W'($urandom_range(1, 'h7F));
            2:       cp = CP_W'($urandom_range('h80, 'h7FF));
            3:       cp = CP_W'($urandom_range('h800, 'hFFFF));
            4:       cp = CP_W'($urandom_range('h10000, 'h10FFFF));
            5, 6:    cp = cp_pool[$urandom_range(0, 15)];
            7:       cp = cp_pool[$urandom_range(0, 15)] ^ CP_W'($urandom_range(0, 63));
            8:       cp = BOUNDARY_CPS[$urandom_range(0, 7)];
            default: cp = CP_W'($urandom_range(0, 255));
        endcase
        cp_pool[$urandom_range(0, 15)] = cp;
        return cp;
    endfunction

    task automatic push_word(input logic cmd, input logic [7:0] data, input logic [CP_W-1:0] cp);
        stim_word_t w;
        w.cmd   = cmd;
        w.data  = cmd ? 8'($urandom_range(0, 255)) : data;
        w.cp    = cmd ? cp : CP_W'($urandom);
        w.typed = 1'b0;
        w.want  = '{ST_NEW, '0, '0, '0, '0};
        stim_q.push_back(w);
    endtask

    task automatic build_random_part();
        int              produced;
        int              k;
        int              keep;
        logic [CP_W-1:0] cp;
        logic [31:0]     raw;
        logic [2:0]      n;
        logic [7:0]      lead;
        produced = 0;
        while (produced < N_RANDOM) begin
            k = $urandom_range(0, 99);
            if (k < 40) begin
                cp  = rand_cp();
                raw = utf8_pack(cp, n);
                for (int i = 0; i < int'(n); i++) begin
                    push_word(1'b0, raw[8*i +: 8], '0);
                end
                produced += n;
            end else if (k < 65) begin
                case ($urandom_range(0, 7))
                    0:       cp = CP_W'($urandom);
                    1:       cp = CP_W'($urandom_range('h110000, 'h1FFFFF));
                    default: cp = rand_cp();
                endcase
                push_word(1'b1, '0, cp);
                produced++;
            end else if (k < 73) begin
                // cut a sequence short, then let a direct word drop it
                raw  = utf8_pack(CP_W'($urandom_range('h80, 'h10FFFF)), n);
                keep = $urandom_range(1, int'(n) - 1);
                for (int i = 0; i < keep; i++) begin
                    push_word(1'b0, raw[8*i +: 8], '0);
                end
                push_word(1'b1, '0, rand_cp());
                produced += keep + 1;
            end else if (k < 80) begin
                lead = $urandom_range(0, 1) ? 8'(8'hF4 + $urandom_range(0, 3))
                                            : 8'($urandom_range('hC0, 'hF7));
                n = (lead >= 8'hF0) ? 3'd4 : (lead >= 8'hE0) ? 3'd3 : 3'd2;
                push_word(1'b0, lead, '0);
                for (int i = 1; i < int'(n); i++) begin
                    push_word(1'b0, $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                         : 8'(8'h80 | $urandom_range(0, 63)), '0);
                end
                produced += n;
            end else if (k < 87) begin
                push_word(1'b0, $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF))
                                                     : 8'($urandom_range('hF8, 'hFF)), '0);
                produced++;
            end else if (k < 90) begin
                push_word(1'b0, 8'h00, '0);
                produced++;
            end else begin
                push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), CP_W'($urandom));
                produced++;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        cp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected word, status", 32'(m_status), 32'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.st) begin
                    flag_mismatch("status", 32'(m_status), 32'(want.st));
                end
                if (m_codepoint_out !== want.cp) begin
                    flag_mismatch("codepoint_out", 32'(m_codepoint_out), 32'(want.cp));
                end
                if (m_utf8_bytes !== want.bytes) begin
                    flag_mismatch("utf8_bytes", m_utf8_bytes, want.bytes);
                end
                if (m_byte_count !== want.cnt) begin
                    flag_mismatch("byte_count", 32'(m_byte_count), 32'(want.cnt));
                end
                if (m_unique_total !== want.total) begin
                    flag_mismatch("unique_total", 32'(m_unique_total), 32'(want.total));
                end
            end
        end
    end

    initial begin
        int stall_pct;
        int stall_left;
        m_ready    = 1'b0;
        stall_pct  = 0;
        stall_left = 0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (stall_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    stall_left = $urandom_range(16, 96);
                end
                stall_left--;
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    initial begin
        stim_word_t w;
        cp_result_t r;
        int         burst_left;
        int         gap;
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_command      = 1'b0;
        s_data_byte    = '0;
        s_codepoint_in = '0;
        foreach (cp_pool[i]) begin
            cp_pool[i] = '0;
        end
        foreach (DIRECTED_ROWS[j]) begin
            w.cmd        = DIRECTED_ROWS[j].cmd;
            w.data       = DIRECTED_ROWS[j].data;
            w.cp         = DIRECTED_ROWS[j].cp;
            w.typed      = DIRECTED_ROWS[j].typed;
            w.want.st    = status_t'(DIRECTED_ROWS[j].st);
            w.want.cp    = DIRECTED_ROWS[j].cpo;
            w.want.bytes = DIRECTED_ROWS[j].bytes;
            w.want.cnt   = DIRECTED_ROWS[j].cnt;
            w.want.total = DIRECTED_ROWS[j].total;
            stim_q.push_back(w);
        end
        build_random_part();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        burst_left = 0;
        for (int i = 0; i < stim_q.size(); i++) begin
            // stall the output while the input keeps offering words
            if (i == N_DIRECTED) begin
                hold_off_req = 1'b1;
                burst_left   = 64;
            end
            if (burst_left == 0) begin
                gap        = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 10);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 100)
                                                         : $urandom_range(1, 30);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
            w = stim_q[i];
            s_valid        <= 1'b1;
            s_command      <= w.cmd;
            s_data_byte    <= w.data;
            s_codepoint_in <= w.cp;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            if (decode_and_collect(w, r)) begin
                pending_results.push_back(w.typed ? w.want : r);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
